// ----- hw/rtl/lpd_pkg.sv -----
// lpd_pkg: shared types and constants of the length-prefixed deframer.
// No dependencies; every other file of the block but lpd_ram imports it.
package lpd_pkg;

    localparam int LEN_W  = 7;
    localparam int BYTE_W = 8;

    // opcodes of an input item
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // register index decoded from paddr
    localparam logic REG_LENGTH_LIMIT = 1'b0;

    localparam logic [LEN_W-1:0] LIMIT_RESET = 7'd64;

    localparam int CMDQ_DEPTH = 2;

    typedef enum logic [1:0] {
        ST_DATA     = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_OVERSIZE = 2'd2,
        ST_REFUSED  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PH_HIGH = 2'd0,
        PH_LOW  = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    // front -> back command: one single result, or a frame dump from the buffer
    typedef struct packed {
        logic             dump;
        t_status          status;
        logic [LEN_W-1:0] len;
    } t_cmd;

endpackage

// ----- hw/rtl/lpd_ram.sv -----
// lpd_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/lpd_front.sv -----
// lpd_front: accepts stream items, tracks the length header, fills the
// payload buffer and posts commands. Depends on lpd_pkg.
module lpd_front #(
    parameter int MAX_FRAME = 64,
    localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_opcode,
    input  logic [lpd_pkg::BYTE_W-1:0] i_data_byte,
    input  logic [lpd_pkg::LEN_W-1:0]  i_limit,
    input  logic                       i_q_full,
    output logic                       o_push,
    output lpd_pkg::t_cmd              o_cmd,
    input  logic                       i_dump_done,
    output logic                       o_wr_en,
    output logic [AW-1:0]              o_wr_addr,
    output logic [lpd_pkg::BYTE_W-1:0] o_wr_data
);

    import lpd_pkg::*;

    localparam logic [10:0] MAX_W = 11'(MAX_FRAME);

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_len_high, n_len_high;
    logic [LEN_W-1:0]  r_declared, n_declared;
    logic [LEN_W-1:0]  r_count, n_count;
    logic              r_broken, n_broken;
    logic              r_busy, n_busy;

    logic             accept;
    logic [LEN_W-1:0] eff_limit;
    logic             oversize;
    logic [LEN_W-1:0] count_inc;
    logic             frame_done;

    // payload bytes wait while the back end still reads the previous frame
    assign o_stall    = i_q_full || (r_busy && (r_phase == PH_DATA));
    assign accept     = i_valid && !o_stall;
    assign eff_limit  = ({4'b0, i_limit} < MAX_W) ? i_limit : MAX_W[LEN_W-1:0];
    assign oversize   = (r_len_high != '0) || (i_data_byte > {1'b0, eff_limit});
    assign count_inc  = r_count + 7'd1;
    assign frame_done = (count_inc == r_declared);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            if (i_opcode == OP_RESTART) begin
                n_phase = PH_HIGH;
            end else if (!r_broken) begin
                case (r_phase)
                    PH_LOW: begin
                        if (!oversize) begin
                            n_phase = (i_data_byte == '0) ? PH_HIGH : PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        if (frame_done) begin
                            n_phase = PH_HIGH;
                        end
                    end
                    default: begin
                        n_phase = PH_LOW;
                    end
                endcase
            end
        end
    end

    // outputs and datapath
    always_comb begin
        o_push     = 1'b0;
        o_cmd      = '{dump: 1'b0, status: ST_REFUSED, len: '0};
        o_wr_en    = 1'b0;
        o_wr_addr  = AW'(r_count);
        o_wr_data  = i_data_byte;
        n_len_high = r_len_high;
        n_declared = r_declared;
        n_count    = r_count;
        n_broken   = r_broken;
        n_busy     = r_busy && !i_dump_done;
        if (accept) begin
            if (i_opcode == OP_RESTART) begin
                n_broken   = 1'b0;
                n_declared = '0;
                n_count    = '0;
            end else if (r_broken) begin
                o_push = 1'b1;
            end else begin
                case (r_phase)
                    PH_LOW: begin
                        if (oversize) begin
                            n_broken     = 1'b1;
                            o_push       = 1'b1;
                            o_cmd.status = ST_OVERSIZE;
                        end else begin
                            n_count    = '0;
                            n_declared = i_data_byte[LEN_W-1:0];
                            if (i_data_byte == '0) begin
                                o_push       = 1'b1;
                                o_cmd.status = ST_EMPTY;
                            end
                        end
                    end
                    PH_DATA: begin
                        o_wr_en = 1'b1;
                        n_count = count_inc;
                        if (frame_done) begin
                            o_push = 1'b1;
                            o_cmd  = '{dump: 1'b1, status: ST_DATA, len: r_declared};
                            n_busy = 1'b1;
                        end
                    end
                    default: begin
                        n_len_high = i_data_byte;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HIGH;
            r_len_high <= '0;
            r_declared <= '0;
            r_count    <= '0;
            r_broken   <= 1'b0;
            r_busy     <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_len_high <= n_len_high;
            r_declared <= n_declared;
            r_count    <= n_count;
            r_broken   <= n_broken;
            r_busy     <= n_busy;
        end
    end

    // a buffer write must never land while a frame readout is pending
    a_wr_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> !r_busy && (r_count < r_declared))
        else $error("payload write during frame readout");

endmodule

// ----- hw/rtl/lpd_cmd_queue.sv -----
// lpd_cmd_queue: short FIFO of commands between front and back.
// Depends on lpd_pkg.
module lpd_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lpd_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_head_valid,
    output lpd_pkg::t_cmd o_head
);

    import lpd_pkg::*;

    localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    t_cmd          r_mem [CMDQ_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_fill;

    assign o_full       = (r_fill == CW'(CMDQ_DEPTH));
    assign o_head_valid = (r_fill != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_fill <= r_fill + CW'(i_push) - CW'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push |-> !o_full) and (i_pop |-> o_head_valid))
        else $error("command queue over- or underflow");

endmodule

// ----- hw/rtl/lpd_back.sv -----
// lpd_back: executes commands; streams buffered frames out of the payload
// RAM into the output register. Depends on lpd_pkg.
module lpd_back #(
    parameter int MAX_FRAME = 64,
    localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_head_valid,
    input  lpd_pkg::t_cmd              i_head,
    output logic                       o_pop,
    output logic                       o_rd_en,
    output logic [AW-1:0]              o_rd_addr,
    input  logic [lpd_pkg::BYTE_W-1:0] i_rd_data,
    output logic                       o_dump_done,
    output logic                       o_valid,
    input  logic                       i_stall,
    output lpd_pkg::t_status           o_status,
    output logic [lpd_pkg::BYTE_W-1:0] o_payload_byte,
    output logic [lpd_pkg::LEN_W-1:0]  o_frame_length,
    output logic                       o_last
);

    import lpd_pkg::*;

    // readout sequencer
    logic             r_active;
    logic [LEN_W-1:0] r_k, r_len;
    // RAM data stage
    logic             r_rd_valid, r_rd_last;
    logic [LEN_W-1:0] r_rd_len;
    // output register
    logic              r_out_valid, r_out_last;
    t_status           r_out_status;
    logic [BYTE_W-1:0] r_out_byte;
    logic [LEN_W-1:0]  r_out_len;

    logic out_free, move, issue, last_issue, pop_single, pop_dump;

    assign out_free   = !r_out_valid || !i_stall;
    assign move       = r_rd_valid && out_free;
    assign issue      = r_active && (!r_rd_valid || out_free);
    assign last_issue = issue && ((r_k + 7'd1) == r_len);
    assign pop_single = !r_active && !r_rd_valid && i_head_valid && !i_head.dump
                        && out_free;
    assign pop_dump   = !r_active && i_head_valid && i_head.dump;

    assign o_pop       = pop_single || pop_dump;
    assign o_rd_en     = issue;
    assign o_rd_addr   = AW'(r_k);
    assign o_dump_done = last_issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop_dump) begin
                r_active <= 1'b1;
            end else if (last_issue) begin
                r_active <= 1'b0;
            end
            r_rd_valid <= issue || (r_rd_valid && !out_free);
            if (move || pop_single) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_dump) begin
            r_k   <= '0;
            r_len <= i_head.len;
        end else if (issue) begin
            r_k <= r_k + 7'd1;
        end
        if (issue) begin
            r_rd_last <= last_issue;
            r_rd_len  <= r_len;
        end
        if (move) begin
            r_out_status <= ST_DATA;
            r_out_byte   <= i_rd_data;
            r_out_len    <= r_rd_len;
            r_out_last   <= r_rd_last;
        end else if (pop_single) begin
            r_out_status <= i_head.status;
            r_out_byte   <= '0;
            r_out_len    <= '0;
            r_out_last   <= 1'b1;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_payload_byte = r_out_byte;
    assign o_frame_length = r_out_len;
    assign o_last         = r_out_last;

    a_readout_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_len != '0) && (r_k < r_len))
        else $error("frame readout out of range");

    a_single_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_DATA))
            |-> (r_out_byte == '0) && (r_out_len == '0) && r_out_last)
        else $error("non-payload result carries payload fields");

endmodule

// ----- hw/rtl/length_prefixed_deframer.sv -----
// length_prefixed_deframer: top level, configuration register and wiring.
// Depends on lpd_pkg, lpd_front, lpd_cmd_queue, lpd_back and lpd_ram.
//
// Splits a byte stream of frames (16-bit big-endian length, then payload)
// back into frames. The front end takes one input item per cycle while
// it does not stall: header bytes, restart items and bytes refused in the
// error state are classified at once; payload bytes are written to a
// MAX_FRAME-deep payload RAM. When the final byte of a frame arrives a
// command goes through a 2-entry queue to the back end, which reads the
// frame out of the RAM's single read port at one byte per cycle while the
// output is not stalled, behind a registered output, marking the final
// byte with last. Empty frames, oversize errors (declared length above
// min(length_limit, MAX_FRAME)) and refused bytes each give a single
// result. The input stalls while the command queue is full; payload bytes
// of the next frame are also held off (stall) until the readout of the
// previous frame has issued its last RAM read.
// length_limit sits at byte address 0 of the APB port; reset value 64.
module length_prefixed_deframer #(
    parameter int MAX_FRAME = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input item channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_opcode,
    input  logic [lpd_pkg::BYTE_W-1:0] i_data_byte,
    // result channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [1:0]                 o_status,
    output logic [lpd_pkg::BYTE_W-1:0] o_payload_byte,
    output logic [lpd_pkg::LEN_W-1:0]  o_frame_length,
    output logic                       o_last,
    // APB configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    import lpd_pkg::*;

    localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;

    logic [LEN_W-1:0] r_limit;

    logic    q_push, q_full, q_pop, q_head_valid;
    t_cmd    q_cmd, q_head;
    logic    dump_done;
    t_status out_status;

    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [BYTE_W-1:0] wr_data, rd_data;

    // configuration register; word index is paddr[2]
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LENGTH_LIMIT) ? {25'd0, r_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_LENGTH_LIMIT)) begin
            r_limit <= pwdata[LEN_W-1:0];
        end
    end

    lpd_front #(.MAX_FRAME(MAX_FRAME)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_data_byte (i_data_byte),
        .i_limit     (r_limit),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (q_cmd),
        .i_dump_done (dump_done),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    lpd_cmd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_cmd        (q_cmd),
        .o_full       (q_full),
        .i_pop        (q_pop),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    lpd_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_FRAME)) u_payload_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lpd_back #(.MAX_FRAME(MAX_FRAME)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (q_head_valid),
        .i_head         (q_head),
        .o_pop          (q_pop),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_dump_done    (dump_done),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (out_status),
        .o_payload_byte (o_payload_byte),
        .o_frame_length (o_frame_length),
        .o_last         (o_last)
    );

    assign o_status = out_status;

endmodule

// ----- dv/lpd_frame_checker.sv -----
`timescale 1ns / 1ps
// lpd_frame_checker: watches both item channels of the deframer, predicts
// every result from the accepted input items and compares in order.
// Depends on lpd_pkg; instantiated beside the block by length_prefixed_deframer_tb.
module lpd_frame_checker #(
    parameter int         MAX_FRAME = 64,
    parameter logic [2:0] REG_ADDR  = 3'd0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic                       i_opcode,
    input  logic [lpd_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [1:0]                 i_status,
    input  logic [lpd_pkg::BYTE_W-1:0] i_payload_byte,
    input  logic [lpd_pkg::LEN_W-1:0]  i_frame_length,
    input  logic                       i_last,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic                       i_pready,
    input  logic [2:0]                 i_paddr,
    input  logic [31:0]                i_pwdata,
    input  logic [31:0]                i_prdata,
    output int                         o_fail_count,
    output int                         o_pending
);
    import lpd_pkg::*;

    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  flen;
        logic              last;
    } t_deframed;

    logic [LEN_W-1:0]  limit_q;
    t_phase            phase_q;
    logic [BYTE_W-1:0] len_high_q;
    int                declared_q;
    int                received_q;
    logic              broken_q;
    logic [BYTE_W-1:0] frame_buf [MAX_FRAME];
    t_deframed         expected_q [$];
    int                mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t lpd_frame_checker: %s: got %0h, want %0h",
                 $time, what, got, want);
    endtask

    function automatic void expect_result(input t_status st, input logic [BYTE_W-1:0] d,
                                          input int flen, input logic lst);
        t_deframed r;
        r.status = st;
        r.data   = d;
        r.flen   = LEN_W'(flen);
        r.last   = lst;
        expected_q.push_back(r);
    endfunction

    // one accepted input item -> zero or more expected results
    task automatic deframe_item(input logic op, input logic [BYTE_W-1:0] b);
        int len;
        int lim;
        if (op == OP_RESTART) begin
            phase_q    = PH_HIGH;
            broken_q   = 1'b0;
            declared_q = 0;
            received_q = 0;
            return;
        end
        if (broken_q) begin
            expect_result(ST_REFUSED, '0, 0, 1'b1);
            return;
        end
        case (phase_q)
            PH_LOW: begin
                // full 16-bit length against the limit, clipped to the buffer
                len = int'({len_high_q, b});
                lim = (int'(limit_q) < MAX_FRAME) ? int'(limit_q) : MAX_FRAME;
                if (len > lim) begin
                    broken_q = 1'b1;
                    expect_result(ST_OVERSIZE, '0, 0, 1'b1);
                end else begin
                    received_q = 0;
                    declared_q = len;
                    if (len == 0) begin
                        phase_q = PH_HIGH;
                        expect_result(ST_EMPTY, '0, 0, 1'b1);
                    end else begin
                        phase_q = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                if (received_q < MAX_FRAME)
                    frame_buf[received_q] = b;
                received_q++;
                if (received_q >= declared_q) begin
                    phase_q = PH_HIGH;
                    for (int k = 0; k < declared_q && k < MAX_FRAME; k++)
                        expect_result(ST_DATA, frame_buf[k], declared_q,
                                      k + 1 == declared_q);
                end
            end
            default: begin
                // high length byte; an unused phase code falls back to it as well
                len_high_q = b;
                phase_q    = PH_LOW;
            end
        endcase
    endtask

    task automatic check_result();
        t_deframed want;
        if (expected_q.size() == 0) begin
            report_mismatch("result with none expected",
                            32'({i_status, i_payload_byte, i_frame_length, i_last}), '0);
            return;
        end
        want = expected_q.pop_front();
        if (i_status !== want.status)
            report_mismatch("status", 32'(i_status), 32'(want.status));
        if (i_payload_byte !== want.data)
            report_mismatch("payload_byte", 32'(i_payload_byte), 32'(want.data));
        if (i_frame_length !== want.flen)
            report_mismatch("frame_length", 32'(i_frame_length), 32'(want.flen));
        if (i_last !== want.last)
            report_mismatch("last", 32'(i_last), 32'(want.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limit_q    = LIMIT_RESET;
            phase_q    = PH_HIGH;
            len_high_q = '0;
            declared_q = 0;
            received_q = 0;
            broken_q   = 1'b0;
            expected_q.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == REG_ADDR) begin
                if (i_pwrite)
                    limit_q = i_pwdata[LEN_W-1:0];
                else if (i_prdata !== 32'(limit_q))
                    report_mismatch("length_limit read-back", i_prdata, 32'(limit_q));
            end
            if (i_in_valid && !i_in_stall)
                deframe_item(i_opcode, i_data_byte);
            if (i_out_valid && !i_out_stall)
                check_result();
        end
        o_pending <= expected_q.size();
    end

endmodule

// ----- dv/length_prefixed_deframer_tb.sv -----
`timescale 1ns / 1ps
// length_prefixed_deframer_tb: drives framed byte streams, restarts and noise
// with random idling on both channels; lpd_frame_checker does the comparing.
// Depends on lpd_pkg, length_prefixed_deframer and lpd_frame_checker.
module length_prefixed_deframer_tb;
    import lpd_pkg::*;

    localparam int         MAX_FRAME   = 64;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         LONG_HOLD   = 400;
    localparam int         DRAIN       = 12;
    localparam logic [2:0] LIMIT_ADDR  = 3'(4 * int'(REG_LENGTH_LIMIT));

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_valid        = 1'b0;
    logic              i_opcode       = OP_BYTE;
    logic [BYTE_W-1:0] i_data_byte    = '0;
    logic              i_stall        = 1'b0;
    logic              psel           = 1'b0;
    logic              penable        = 1'b0;
    logic              pwrite         = 1'b0;
    logic [2:0]        paddr          = '0;
    logic [31:0]       pwdata         = '0;
    logic              o_stall;
    logic              o_valid;
    logic [1:0]        o_status;
    logic [BYTE_W-1:0] o_payload_byte;
    logic [LEN_W-1:0]  o_frame_length;
    logic              o_last;
    logic [31:0]       prdata;
    logic              pready;

    bit calm      = 1'b0;   // no drawn idling on either side while set
    bit hold_req  = 1'b0;   // toggled to ask the receiver for a long hold-off
    bit hold_seen = 1'b0;
    int stall_left;
    int hold_left;
    int cycles     = 0;
    int items_sent = 0;
    int limit_now  = 64;    // mirror of length_limit for shaping stimulus
    int fail_count;
    int pending;

    length_prefixed_deframer #(.MAX_FRAME(MAX_FRAME)) u_dut (
        .i_clk, .i_rst_n,
        .i_valid, .o_stall, .i_opcode, .i_data_byte,
        .o_valid, .i_stall, .o_status, .o_payload_byte, .o_frame_length, .o_last,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    lpd_frame_checker #(.MAX_FRAME(MAX_FRAME), .REG_ADDR(LIMIT_ADDR)) u_checker (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_opcode, .i_data_byte,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_status(o_status), .i_payload_byte(o_payload_byte),
        .i_frame_length(o_frame_length), .i_last(o_last),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata), .i_prdata(prdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("length_prefixed_deframer_tb: done, errors");
            $finish;
        end
    end

    function automatic int idle_draw();
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    // Receiver: a drawn stall per accepted result, plus the long hold-off
    // that the stimulus asks for, counted here in cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (o_valid && !i_stall)
                stall_left = idle_draw();
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Called at a rising edge; returns at the edge that accepts the item.
    task automatic send_item(input logic op, input logic [BYTE_W-1:0] b);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_opcode    <= op;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_restart();
        send_item(OP_RESTART, 8'($urandom));
    endtask

    // header for len, then nbytes random payload bytes
    task automatic send_frame(input int len, input int nbytes);
        send_item(OP_BYTE, len[15:8]);
        send_item(OP_BYTE, len[7:0]);
        repeat (nbytes) send_item(OP_BYTE, 8'($urandom));
    endtask

    // Stop offering items until every expected result has come, then let
    // the block finish any work that gives no result.
    task automatic settle(input int extra);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic apb_read();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= LIMIT_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_length_limit(input logic [LEN_W-1:0] v);
        settle(DRAIN);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        apb_read();
        limit_now = int'(v);
    endtask

    function automatic int eff_limit();
        return (limit_now < MAX_FRAME) ? limit_now : MAX_FRAME;
    endfunction

    // mostly short frames, a few empty and a few at the limit
    function automatic int pick_length(input int lim);
        int r;
        r = $urandom_range(0, 99);
        if (lim == 0 || r < 8)
            return 0;
        if (r < 12)
            return lim;
        if (r < 80)
            return $urandom_range(1, (lim < 8) ? lim : 8);
        return $urandom_range(1, lim);
    endfunction

    task automatic random_mix(input int n);
        int start;
        int pick;
        int len;
        int lim;
        start = items_sent;
        while (items_sent - start < n) begin
            lim  = eff_limit();
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                len = pick_length(lim);
                send_frame(len, len);
            end else if (pick < 75) begin
                // oversize, a few refused bytes, then recover
                if ($urandom_range(0, 1))
                    len = $urandom_range(lim + 1, 255);
                else
                    len = $urandom_range(256, 65535);
                send_frame(len, $urandom_range(0, 3));
                send_restart();
            end else if (pick < 87) begin
                // frame cut short by a restart
                if (lim == 0) begin
                    send_item(OP_BYTE, 8'($urandom));
                end else begin
                    len = $urandom_range(1, lim);
                    send_frame(len, $urandom_range(0, len - 1));
                end
                send_restart();
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item(1'($urandom_range(0, 1)), 8'($urandom));
                send_restart();
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_read();

        // directed: empty frame, one-byte and two-byte frames
        send_frame(0, 0);
        send_item(OP_BYTE, 8'h00); send_item(OP_BYTE, 8'h01); send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'h00); send_item(OP_BYTE, 8'h02);
        send_item(OP_BYTE, 8'hFF); send_item(OP_BYTE, 8'hA5);
        // restart while healthy
        send_item(OP_RESTART, 8'hFF);
        // one past the limit, refused byte, recover
        send_item(OP_BYTE, 8'h00); send_item(OP_BYTE, 8'h41);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_RESTART, 8'h00);
        // largest 16-bit length
        send_item(OP_BYTE, 8'hFF); send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h00);
        send_restart();
        // restart in the middle of a payload
        send_item(OP_BYTE, 8'h00); send_item(OP_BYTE, 8'h03);
        send_item(OP_BYTE, 8'h5A);
        send_restart();

        // zero limit: only empty frames get through
        set_length_limit(7'd0);
        send_frame(0, 0);
        send_frame(1, 0);
        send_restart();
        random_mix(15);

        // limit above the buffer acts as the buffer size
        set_length_limit(7'd127);
        send_frame(65, 0);
        send_restart();
        random_mix(110);

        // smallest nonzero limit, back to back on both sides
        set_length_limit(7'd1);
        calm <= 1'b1;
        random_mix(40);
        calm <= 1'b0;

        // long receiver hold-off while the sender keeps pushing: the buffer
        // and the command queue fill up and the input stalls
        set_length_limit(7'($urandom_range(2, 63)));
        calm     <= 1'b1;
        hold_req <= ~hold_req;
        send_frame(eff_limit(), eff_limit());
        random_mix(40);
        calm <= 1'b0;
        // sender waits for every result before going on
        settle(0);
        random_mix(60);

        set_length_limit(7'd64);
        random_mix(90);

        settle(DRAIN * 2);
        if (fail_count == 0 && pending == 0)
            $display("length_prefixed_deframer_tb: done, clean");
        else
            $display("length_prefixed_deframer_tb: done, errors");
        $finish;
    end

endmodule
